FILE: sv/circular_deque_with_cursor_core_macros.svh
// Assertion macros used by the port-level checker of the circular deque core.
// Needs nothing else; each macro samples on the rising edge of the clock given.
`ifndef CIRCULAR_DEQUE_WITH_CURSOR_CORE_MACROS_SVH
`define CIRCULAR_DEQUE_WITH_CURSOR_CORE_MACROS_SVH

// Same-cycle implication, held off while reset is asserted
`define CDQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");

// Next-cycle implication, held off while reset is asserted
`define CDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

FILE: sv/cdq_pkg.sv
// Package of the circular deque core: command codes, position-reduction constants and
// the control and status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package cdq_pkg;

	localparam logic [2:0] CMD_PUSH_HEAD = 3'd0;
	localparam logic [2:0] CMD_PUSH_TAIL = 3'd1;
	localparam logic [2:0] CMD_POP_HEAD  = 3'd2;
	localparam logic [2:0] CMD_POP_TAIL  = 3'd3;
	localparam logic [2:0] CMD_SET_POS   = 3'd4;
	localparam logic [2:0] CMD_READ_CUR  = 3'd5;

	// Modulo reduction of a position: width and number of restoring steps
	localparam int MOD_W     = 12;
	localparam int MOD_STEPS = 7;
	localparam int NEG_SHIFT = 5;

	typedef struct packed {
		logic accept;
		logic exec;
		logic clear;
		logic restart;
	} cdq_ctl_t;

	typedef struct packed {
		logic clr_last;
	} cdq_sts_t;

endpackage

FILE: sv/cdq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module cdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: sv/cdq_ctrl.sv
// Controller of the circular deque core: clear pass, idle and execute states.
// Depends on cdq_pkg for the control and status structs.
`timescale 1ns / 1ps

module cdq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              cfg_we,
	input  cdq_pkg::cdq_sts_t sts,
	output logic              busy,
	output logic              done,
	output cdq_pkg::cdq_ctl_t ctl
);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_EXEC  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d = state_q;
		priority if (cfg_we) begin
			state_d = ST_CLEAR;
		end else if (state_q == ST_CLEAR) begin
			if (sts.clr_last) begin
				state_d = ST_IDLE;
			end
		end else if (state_q == ST_IDLE) begin
			if (start) begin
				state_d = ST_EXEC;
			end
		end else begin
			state_d = ST_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy        = (state_q != ST_IDLE);
	assign done        = (state_q == ST_EXEC);
	assign ctl.accept  = (state_q == ST_IDLE) && start;
	assign ctl.exec    = (state_q == ST_EXEC);
	assign ctl.clear   = (state_q == ST_CLEAR);
	assign ctl.restart = cfg_we;

endmodule

FILE: sv/cdq_dp.sv
// Datapath of the circular deque core: capacity, head, tail and cursor registers,
// position reduction and the slot RAM. Depends on cdq_pkg and cdq_ram.
`timescale 1ns / 1ps

module cdq_dp #(
	parameter int DEPTH      = 16,
	parameter int WORD_WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cdq_pkg::cdq_ctl_t ctl,
	input  logic [2:0]        cmd,
	input  logic [31:0]       value,
	input  logic              whence,
	input  logic signed [5:0] offset,
	input  logic              cfg_we,
	input  logic [4:0]        capacity,
	output cdq_pkg::cdq_sts_t sts,
	output logic [31:0]       data_out
);

	localparam int AW      = $clog2(DEPTH);
	localparam int CAP_MAX = (DEPTH < 31) ? DEPTH : 31;
	localparam int CAPW    = $clog2(CAP_MAX + 1);
	localparam int CAP_RST = (DEPTH < 16) ? DEPTH : 16;

	logic [CAPW-1:0]       cap_q;
	logic [CAPW-1:0]       cap_new;
	logic [CAPW-1:0]       cap_new_m1;
	logic [AW-1:0]         cap_m1;
	logic [AW-1:0]         head_q, tail_q, cursor_q, clr_cnt_q;
	logic [AW-1:0]         head_dec, head_inc, tail_dec, tail_inc, pos_next;
	logic [2:0]            cmd_q;
	logic [WORD_WIDTH-1:0] value_q;
	logic                  whence_q;
	logic signed [5:0]     offset_q;

	logic                  ram_we;
	logic [AW-1:0]         ram_waddr, ram_raddr;
	logic [WORD_WIDTH-1:0] ram_wdata, ram_rdata;

	logic signed [cdq_pkg::MOD_W-1:0] base_s, ofs_s, sum_s;
	logic [cdq_pkg::MOD_W-1:0]        rem, sub;

	// Clamp a written capacity into 1..DEPTH
	always_comb begin
		priority if (capacity == 5'd0) begin
			cap_new = CAPW'(1);
		end else if (int'(capacity) > DEPTH) begin
			cap_new = CAPW'(DEPTH);
		end else begin
			cap_new = CAPW'(capacity);
		end
	end

	assign cap_new_m1 = cap_new - CAPW'(1);
	assign cap_m1     = AW'(cap_q - CAPW'(1));

	assign head_dec = (head_q == '0) ? cap_m1 : head_q - AW'(1);
	assign head_inc = (head_q == cap_m1) ? '0 : head_q + AW'(1);
	assign tail_dec = (tail_q == '0) ? cap_m1 : tail_q - AW'(1);
	assign tail_inc = (tail_q == cap_m1) ? '0 : tail_q + AW'(1);

	// Set position: base plus or minus offset, reduced modulo capacity by
	// restoring subtraction of shifted capacity
	always_comb begin
		base_s = $signed(cdq_pkg::MOD_W'(whence_q ? tail_q : head_q));
		ofs_s  = cdq_pkg::MOD_W'(offset_q);
		sum_s  = whence_q ? (base_s - ofs_s) : (base_s + ofs_s);
		if (sum_s[cdq_pkg::MOD_W-1]) begin
			rem = $unsigned(sum_s)
				+ (cdq_pkg::MOD_W'(cap_q) << cdq_pkg::NEG_SHIFT);
		end else begin
			rem = $unsigned(sum_s);
		end
		for (int k = cdq_pkg::MOD_STEPS - 1; k >= 0; k--) begin
			sub = cdq_pkg::MOD_W'(cap_q) << k;
			if (rem >= sub) begin
				rem = rem - sub;
			end
		end
		pos_next = AW'(rem);
	end

	// Capture the transaction
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			cmd_q    <= cmd;
			value_q  <= WORD_WIDTH'(value);
			whence_q <= whence;
			offset_q <= offset;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q    <= CAPW'(CAP_RST);
			head_q   <= '0;
			tail_q   <= AW'(CAP_RST - 1);
			cursor_q <= '0;
		end else if (cfg_we) begin
			cap_q    <= cap_new;
			head_q   <= '0;
			tail_q   <= AW'(cap_new_m1);
			cursor_q <= '0;
		end else if (ctl.exec) begin
			unique case (cmd_q)
				cdq_pkg::CMD_PUSH_HEAD: begin
					head_q   <= head_dec;
					cursor_q <= head_dec;
				end
				cdq_pkg::CMD_PUSH_TAIL: begin
					tail_q <= tail_inc;
				end
				cdq_pkg::CMD_POP_HEAD: begin
					head_q   <= head_inc;
					cursor_q <= head_inc;
				end
				cdq_pkg::CMD_POP_TAIL: begin
					tail_q <= tail_dec;
				end
				cdq_pkg::CMD_SET_POS: begin
					cursor_q <= pos_next;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (ctl.restart) begin
			clr_cnt_q <= '0;
		end else if (ctl.clear) begin
			clr_cnt_q <= clr_cnt_q + AW'(1);
		end
	end

	assign sts.clr_last = (clr_cnt_q == AW'(DEPTH - 1));

	// Read address follows the incoming command so data is ready in execute
	always_comb begin
		priority if (cmd == cdq_pkg::CMD_POP_TAIL) begin
			ram_raddr = tail_q;
		end else if (cmd == cdq_pkg::CMD_READ_CUR) begin
			ram_raddr = cursor_q;
		end else begin
			ram_raddr = head_q;
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = head_q;
		ram_wdata = '0;
		priority if (ctl.clear) begin
			ram_we    = 1'b1;
			ram_waddr = clr_cnt_q;
		end else if (ctl.exec) begin
			unique case (cmd_q)
				cdq_pkg::CMD_PUSH_HEAD: begin
					ram_we    = 1'b1;
					ram_waddr = head_dec;
					ram_wdata = value_q;
				end
				cdq_pkg::CMD_PUSH_TAIL: begin
					ram_we    = 1'b1;
					ram_waddr = tail_inc;
					ram_wdata = value_q;
				end
				cdq_pkg::CMD_POP_HEAD: begin
					ram_we    = 1'b1;
					ram_waddr = head_q;
				end
				cdq_pkg::CMD_POP_TAIL: begin
					ram_we    = 1'b1;
					ram_waddr = tail_q;
				end
				default: begin
				end
			endcase
		end
	end

	cdq_ram #(
		.WIDTH (WORD_WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign data_out = (cmd_q == cdq_pkg::CMD_POP_HEAD || cmd_q == cdq_pkg::CMD_POP_TAIL
		|| cmd_q == cdq_pkg::CMD_READ_CUR) ? 32'(ram_rdata) : 32'd0;

endmodule

FILE: sv/circular_deque_with_cursor_core.sv
// Top level of the circular deque core: controller plus datapath.
// Depends on cdq_pkg, cdq_ctrl, cdq_dp (and through it cdq_ram).
//
//  channel   ports                               handshake
//  command   cmd, value, whence, offset          start high while busy low
//  result    data_out                            done, one cycle, no back-pressure
//  config    capacity                            cfg_we, taken at once
//
// The slot RAM is read in the accept cycle; the result shows with done in the
// next one, when the write-back happens.
// A new command can be taken in the cycle after done.
// After reset and after each capacity write, a clearing pass zeroes all DEPTH
// slots of the RAM, one slot a cycle, with busy high.
`timescale 1ns / 1ps

module circular_deque_with_cursor_core #(
	parameter int DEPTH      = 16,
	parameter int WORD_WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [2:0]        cmd,
	input  logic [31:0]       value,
	input  logic              whence,
	input  logic signed [5:0] offset,
	output logic              done,
	output logic [31:0]       data_out,
	input  logic              cfg_we,
	input  logic [4:0]        capacity
);

	cdq_pkg::cdq_ctl_t ctl;
	cdq_pkg::cdq_sts_t sts;

	cdq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cfg_we (cfg_we),
		.sts    (sts),
		.busy   (busy),
		.done   (done),
		.ctl    (ctl)
	);

	cdq_dp #(
		.DEPTH      (DEPTH),
		.WORD_WIDTH (WORD_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.cmd      (cmd),
		.value    (value),
		.whence   (whence),
		.offset   (offset),
		.cfg_we   (cfg_we),
		.capacity (capacity),
		.sts      (sts),
		.data_out (data_out)
	);

endmodule

FILE: sv/cdq_checker.sv
// Port-level checker of the circular deque core and its bind to the top level.
// Depends on circular_deque_with_cursor_core_macros.svh.
`timescale 1ns / 1ps
`include "circular_deque_with_cursor_core_macros.svh"

module cdq_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic cfg_we
);

	// A result only appears while the block is busy with its transaction
	`CDQ_ASSERT_NOW(a_done_busy, clk, arst_n, done, busy)
	// An accepted command gives its result in the next cycle
	`CDQ_ASSERT_NEXT(a_accept_done, clk, arst_n, start && !busy && !cfg_we, done)
	// One strobe per transaction
	`CDQ_ASSERT_NEXT(a_done_pulse, clk, arst_n, done, !done)
	// A capacity write starts the clearing pass
	`CDQ_ASSERT_NEXT(a_cfg_clear, clk, arst_n, cfg_we, busy && !done)

endmodule

bind circular_deque_with_cursor_core cdq_checker u_cdq_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.cfg_we (cfg_we)
);

FILE: verif/cdq_deque_checker.sv
// Checker for the circular deque core: tracks slots, head, tail and cursor,
// predicts data_out for every command taken, and compares it on done.
// Depends on cdq_pkg for the command codes.
`timescale 1ns / 1ps

module cdq_deque_checker #(
	parameter int DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  logic [2:0]        cmd,
	input  logic [31:0]       value,
	input  logic              whence,
	input  logic signed [5:0] offset,
	input  logic              done,
	input  logic [31:0]       data_out,
	input  logic              cfg_we,
	input  logic [4:0]        capacity,
	output int                mismatches,
	output int                pending
);

	localparam int PW = $clog2(DEPTH);
	localparam int RST_SIZE = (DEPTH < 16) ? DEPTH : 16;

	logic [31:0]   slot_mem [DEPTH];
	logic [PW-1:0] head_pos;
	logic [PW-1:0] tail_pos;
	logic [PW-1:0] cursor_pos;
	int            ring_size;
	int            fail_count;
	logic [31:0]   expected_words [$];

	// true modulo: result always lands in 0..ring_size-1
	function automatic logic [PW-1:0] ring_move(input logic [PW-1:0] base, input int delta);
		int r;
		r = (int'(base) + delta) % ring_size;
		if (r < 0) r += ring_size;
		return r[PW-1:0];
	endfunction

	task automatic reload_ring(input int size);
		ring_size = size;
		foreach (slot_mem[i]) slot_mem[i] = '0;
		head_pos   = '0;
		tail_pos   = PW'(size - 1);
		cursor_pos = '0;
	endtask

	function automatic logic [31:0] deque_apply(input logic [2:0] op, input logic [31:0] word,
			input logic from_tail, input logic signed [5:0] offs);
		logic [31:0] res;
		res = '0;
		case (op)
			cdq_pkg::CMD_PUSH_HEAD: begin
				head_pos = ring_move(head_pos, -1);
				slot_mem[head_pos] = word;
				cursor_pos = head_pos;
			end
			cdq_pkg::CMD_PUSH_TAIL: begin
				tail_pos = ring_move(tail_pos, 1);
				slot_mem[tail_pos] = word;
			end
			cdq_pkg::CMD_POP_HEAD: begin
				res = slot_mem[head_pos];
				slot_mem[head_pos] = '0;
				head_pos = ring_move(head_pos, 1);
				cursor_pos = head_pos;
			end
			cdq_pkg::CMD_POP_TAIL: begin
				res = slot_mem[tail_pos];
				slot_mem[tail_pos] = '0;
				tail_pos = ring_move(tail_pos, -1);
			end
			cdq_pkg::CMD_SET_POS: begin
				// from the tail the distance counts back toward the head
				if (from_tail) cursor_pos = ring_move(tail_pos, -int'(offs));
				else cursor_pos = ring_move(head_pos, int'(offs));
			end
			cdq_pkg::CMD_READ_CUR: begin
				res = slot_mem[cursor_pos];
			end
			default: ;
		endcase
		return res;
	endfunction

	task automatic log_fault(input string what, input logic [31:0] want, input logic [31:0] got);
		fail_count++;
		if (fail_count <= 10)
			$display("%t checker: %s, expected %h, got %h", $realtime, what, want, got);
	endtask

	always @(posedge clk) begin
		logic [31:0] want;
		if (!arst_n) begin
			reload_ring(RST_SIZE);
			expected_words.delete();
			fail_count = 0;
			mismatches <= 0;
			pending <= 0;
		end else begin
			// retire the oldest transaction before taking a new one in the same cycle
			if (done) begin
				if (expected_words.size() == 0) begin
					log_fault("result with no command outstanding", '0, data_out);
				end else begin
					want = expected_words.pop_front();
					if (data_out !== want) log_fault("data_out mismatch", want, data_out);
				end
			end
			if (cfg_we)
				reload_ring((capacity == 0) ? 1 : (capacity > DEPTH) ? DEPTH : int'(capacity));
			if (start && !busy)
				expected_words.push_back(deque_apply(cmd, value, whence, offset));
			pending <= expected_words.size();
			mismatches <= fail_count;
		end
	end

endmodule

FILE: verif/tb_top.sv
// Testbench top for the circular deque core: clock, reset, command stimulus
// and capacity writes. Depends on cdq_pkg, the core and cdq_deque_checker.
`timescale 1ns / 1ps

module tb_top;

	localparam logic [2:0] CMD_SPARE_6 = 3'd6;
	localparam logic [2:0] CMD_SPARE_7 = 3'd7;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int ITEMS_PER_PHASE = 63;

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              start    = 1'b0;
	logic              busy;
	logic [2:0]        cmd      = cdq_pkg::CMD_READ_CUR;
	logic [31:0]       value    = '0;
	logic              whence   = 1'b0;
	logic signed [5:0] offset   = '0;
	logic              done;
	logic [31:0]       data_out;
	logic              cfg_we   = 1'b0;
	logic [4:0]        capacity = 5'd16;

	int mismatches;
	int pending;
	int gap_mode = 2;
	int issued = 0;
	int caps_written = 0;
	int stall_cycles = 0;

	always #2 clk = ~clk;

	circular_deque_with_cursor_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.cmd      (cmd),
		.value    (value),
		.whence   (whence),
		.offset   (offset),
		.done     (done),
		.data_out (data_out),
		.cfg_we   (cfg_we),
		.capacity (capacity)
	);

	cdq_deque_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.value      (value),
		.whence     (whence),
		.offset     (offset),
		.done       (done),
		.data_out   (data_out),
		.cfg_we     (cfg_we),
		.capacity   (capacity),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always @(posedge clk) begin
		if (!arst_n || cfg_we || done || (start && !busy)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// hold start high across back-to-back commands; drop it only for a gap
	task automatic issue(input logic [2:0] op, input logic [31:0] word, input logic from_tail,
			input logic signed [5:0] offs);
		int gap;
		case (gap_mode)
			0: gap = 0;
			1: gap = $urandom_range(0, 19);
			default: gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 19) : 0;
		endcase
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start  <= 1'b1;
		cmd    <= op;
		value  <= word;
		whence <= from_tail;
		offset <= offs;
		@(posedge clk);
		while (busy) @(posedge clk);
		issued++;
	endtask

	// hold off new commands until every result is back
	task automatic settle();
		start <= 1'b0;
		repeat (2) @(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_capacity(input logic [4:0] slots);
		settle();
		while (busy) @(posedge clk);
		cfg_we   <= 1'b1;
		capacity <= slots;
		@(posedge clk);
		cfg_we <= 1'b0;
		caps_written++;
	endtask

	task automatic random_item(input int span);
		int          pick;
		int          offs;
		logic [2:0]  op;
		logic [31:0] word;
		pick = $urandom_range(0, 99);
		if (pick < 20) op = cdq_pkg::CMD_PUSH_HEAD;
		else if (pick < 38) op = cdq_pkg::CMD_PUSH_TAIL;
		else if (pick < 52) op = cdq_pkg::CMD_POP_HEAD;
		else if (pick < 64) op = cdq_pkg::CMD_POP_TAIL;
		else if (pick < 80) op = cdq_pkg::CMD_SET_POS;
		else if (pick < 96) op = cdq_pkg::CMD_READ_CUR;
		else if (pick < 98) op = CMD_SPARE_6;
		else op = CMD_SPARE_7;
		case ($urandom_range(0, 7))
			0: word = '0;
			1: word = '1;
			default: word = $urandom;
		endcase
		// half the offsets stay within plus or minus the ring size, the rest span the 6-bit range
		if ($urandom_range(0, 1)) offs = $urandom_range(0, 2 * span) - span;
		else offs = $urandom_range(0, 63);
		issue(op, word, 1'($urandom_range(0, 1)), 6'(offs));
	endtask

	initial begin
		logic [4:0] phase_caps [10];
		int         span;
		int         pause_at;
		phase_caps = '{5'd1, 5'd0, 5'd31, 5'd2, 5'd16, 5'd3, 5'd7, 5'd17, 5'd5, 5'd12};
		phase_caps[9] = 5'($urandom_range(0, 31));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty pops, extreme words, cursor from both ends, spare codes
		issue(cdq_pkg::CMD_POP_HEAD, 32'h0, 1'b0, 6'sd0);
		issue(cdq_pkg::CMD_POP_TAIL, 32'h0, 1'b0, 6'sd0);
		issue(cdq_pkg::CMD_PUSH_HEAD, 32'hFFFF_FFFF, 1'b1, -6'sd1);
		issue(cdq_pkg::CMD_PUSH_TAIL, 32'h0000_0000, 1'b0, 6'sd0);
		issue(cdq_pkg::CMD_PUSH_TAIL, 32'hA5A5_5A5A, 1'b0, 6'sd0);
		issue(cdq_pkg::CMD_PUSH_HEAD, 32'h8000_0001, 1'b0, 6'sd0);
		issue(cdq_pkg::CMD_READ_CUR, 32'h0, 1'b0, 6'sd0);
		issue(cdq_pkg::CMD_SET_POS, 32'h0, 1'b0, 6'sd31);
		issue(cdq_pkg::CMD_READ_CUR, 32'h0, 1'b0, 6'sd0);
		issue(cdq_pkg::CMD_SET_POS, 32'h0, 1'b0, -6'sd32);
		issue(cdq_pkg::CMD_READ_CUR, 32'h0, 1'b0, 6'sd0);
		issue(cdq_pkg::CMD_SET_POS, 32'h0, 1'b1, 6'sd0);
		issue(cdq_pkg::CMD_READ_CUR, 32'h0, 1'b0, 6'sd0);
		issue(cdq_pkg::CMD_SET_POS, 32'h0, 1'b1, -6'sd16);
		issue(cdq_pkg::CMD_READ_CUR, 32'h0, 1'b0, 6'sd0);
		issue(cdq_pkg::CMD_SET_POS, 32'h0, 1'b0, 6'sd16);
		issue(cdq_pkg::CMD_READ_CUR, 32'h0, 1'b0, 6'sd0);
		issue(CMD_SPARE_6, 32'hFFFF_FFFF, 1'b1, -6'sd1);
		issue(CMD_SPARE_7, 32'hFFFF_FFFF, 1'b1, -6'sd1);
		issue(cdq_pkg::CMD_POP_HEAD, 32'h0, 1'b0, 6'sd0);
		issue(cdq_pkg::CMD_POP_TAIL, 32'h0, 1'b0, 6'sd0);
		issue(cdq_pkg::CMD_POP_HEAD, 32'h0, 1'b0, 6'sd0);
		issue(cdq_pkg::CMD_POP_TAIL, 32'h0, 1'b0, 6'sd0);
		issue(cdq_pkg::CMD_READ_CUR, 32'h0, 1'b0, 6'sd0);

		foreach (phase_caps[p]) begin
			set_capacity(phase_caps[p]);
			span = (phase_caps[p] == 0) ? 1 : (phase_caps[p] > 16) ? 16 : int'(phase_caps[p]);
			gap_mode = p % 3;
			pause_at = $urandom_range(5, ITEMS_PER_PHASE - 5);
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				if (i == pause_at) settle();
				random_item(span);
			end
		end

		settle();
		repeat (8) @(posedge clk);
		$display("Summary: %0d commands over %0d capacity writes (0 through 31, clamped ones too).",
			issued, caps_written);
		if (mismatches == 0 && pending == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
